>>> hdl/pli_pkg.sv
// Shared types and codes for the positional list with insert and delete.
package pli_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int IDX_W  = 6;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LIST   = 2'd2
  } func_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_WRONG_POS = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] sel;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

endpackage

>>> hdl/pli_cell.sv
// One storage cell of the list chain, shifting to or from its neighbors.
module pli_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  pli_pkg::cell_ctrl_t          ctrl,
  input  logic [pli_pkg::DATA_W-1:0]   ins_value,
  input  logic [pli_pkg::DATA_W-1:0]   head_value,
  input  logic [pli_pkg::DATA_W-1:0]   left_value,
  input  logic [pli_pkg::DATA_W-1:0]   right_value,
  output logic [pli_pkg::DATA_W-1:0]   data_out
);

  localparam logic [pli_pkg::IDX_W-1:0] MY_IDX = pli_pkg::IDX_W'(IDX);

  logic [pli_pkg::DATA_W-1:0] data_r;
  logic [pli_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.cmd)
      pli_pkg::CELL_INSERT: begin
        if (MY_IDX == ctrl.sel) begin
          data_nxt = ins_value;
        end else if (MY_IDX > ctrl.sel) begin
          data_nxt = left_value;
        end
      end
      pli_pkg::CELL_DELETE: begin
        if (MY_IDX >= ctrl.sel) begin
          data_nxt = right_value;
        end
      end
      pli_pkg::CELL_ROTATE: begin
        if (MY_IDX == ctrl.sel) begin
          data_nxt = head_value;
        end else if (MY_IDX < ctrl.sel) begin
          data_nxt = right_value;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

>>> hdl/positional_list_insert_delete.sv
// Top level of the positional list: control, result register and the cell chain.
// Insert, delete and undefined operations each give one result word, which is registered.
// A list operation emits one entry per cycle from the head cell while the chain rotates,
// when the output is not stalled; no new word is taken until the last entry is registered.
// Throughput is one item per cycle for insert and delete when the output is not stalled.
// Synchronous active-low reset empties the list; cell contents stay undefined until written.
module positional_list_insert_delete #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position [5:0], value [37:6], zero fill [39:38]
  input  logic [1:0]  in_tuser,   // func [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // entry_value [31:0], entry_index [37:32],
                                  // entry_count [43:38], zero fill [47:44]
  output logic [1:0]  out_tuser,  // status [1:0]
  output logic        out_tlast
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > pli_pkg::POS_W) ? CW : pli_pkg::POS_W) + 1;
  localparam int DW   = pli_pkg::DATA_W;

  logic [DW-1:0] cell_q [DEPTH];
  pli_pkg::cell_ctrl_t cell_ctrl;

  pli_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [DW-1:0]   out_value_r, out_value_nxt;
  logic [5:0]      out_index_r, out_index_nxt;
  logic [5:0]      out_count_r, out_count_nxt;
  logic            out_last_r, out_last_nxt;

  logic                      slot_free;
  logic                      in_fire;
  pli_pkg::func_t            func;
  logic [pli_pkg::POS_W-1:0] pos;
  logic [DW-1:0]             ins_value;
  logic [CMPW-1:0]           pos_ext;
  logic [CMPW-1:0]           cnt_ext;
  logic [CW-1:0]             k_inc;

  assign func      = pli_pkg::func_t'(in_tuser);
  assign pos       = in_tdata[5:0];
  assign ins_value = in_tdata[37:6];
  assign pos_ext   = CMPW'(pos);
  assign cnt_ext   = CMPW'(cnt_r);
  assign k_inc     = k_r + 1'b1;
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == pli_pkg::S_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    cell_ctrl.cmd  = pli_pkg::CELL_HOLD;
    cell_ctrl.sel  = '0;
    case (state_r)
      pli_pkg::S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pli_pkg::STAT_OK;
          out_value_nxt  = '0;
          out_index_nxt  = '0;
          out_count_nxt  = 6'(cnt_r);
          out_last_nxt   = 1'b1;
          case (func)
            pli_pkg::FUNC_INSERT: begin
              if (cnt_ext >= CMPW'(DEPTH)) begin
                out_status_nxt = pli_pkg::STAT_FULL;
              end else if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
                out_status_nxt = pli_pkg::STAT_WRONG_POS;
              end else begin
                cell_ctrl.cmd = pli_pkg::CELL_INSERT;
                cell_ctrl.sel = pli_pkg::IDX_W'(pos - 1'b1);
                cnt_nxt       = cnt_r + 1'b1;
                out_count_nxt = 6'(cnt_r + 1'b1);
              end
            end
            pli_pkg::FUNC_DELETE: begin
              if (cnt_r == '0) begin
                out_status_nxt = pli_pkg::STAT_EMPTY;
              end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                out_status_nxt = pli_pkg::STAT_WRONG_POS;
              end else begin
                cell_ctrl.cmd = pli_pkg::CELL_DELETE;
                cell_ctrl.sel = pli_pkg::IDX_W'(pos - 1'b1);
                cnt_nxt       = cnt_r - 1'b1;
                out_count_nxt = 6'(cnt_r - 1'b1);
              end
            end
            pli_pkg::FUNC_LIST: begin
              if (cnt_r == '0) begin
                out_status_nxt = pli_pkg::STAT_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                k_nxt         = '0;
                state_nxt     = pli_pkg::S_LIST;
              end
            end
            default: begin
              out_status_nxt = pli_pkg::STAT_OK;
            end
          endcase
        end
      end
      pli_pkg::S_LIST: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pli_pkg::STAT_OK;
          out_value_nxt  = cell_q[0];
          out_index_nxt  = 6'(k_inc);
          out_count_nxt  = 6'(cnt_r);
          out_last_nxt   = (k_inc == cnt_r);
          cell_ctrl.cmd  = pli_pkg::CELL_ROTATE;
          cell_ctrl.sel  = pli_pkg::IDX_W'(cnt_r - 1'b1);
          k_nxt          = k_inc;
          if (k_inc == cnt_r) begin
            state_nxt = pli_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = pli_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pli_pkg::S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DW-1:0] left_value;
    logic [DW-1:0] right_value;
    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_inner_left
      assign left_value = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_final
      assign right_value = '0;
    end else begin : g_inner_right
      assign right_value = cell_q[i+1];
    end
    pli_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .ins_value  (ins_value),
      .head_value (cell_q[0]),
      .left_value (left_value),
      .right_value(right_value),
      .data_out   (cell_q[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_count_r, out_index_r, out_value_r};

endmodule

>>> dv/list_checker.sv
`timescale 1ns / 1ps
// Checker that predicts and compares every result word of the positional list.
module list_checker #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // position [5:0], value [37:6], zero fill [39:38]
  input  logic [1:0]  in_tuser,   // func [1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // entry_value [31:0], entry_index [37:32],
                                  // entry_count [43:38], zero fill [47:44]
  input  logic [1:0]  out_tuser,  // status [1:0]
  input  logic        out_tlast,
  output int          fail_count,
  output int          due_count
);

  typedef struct packed {
    logic [1:0]                 status;
    logic [pli_pkg::DATA_W-1:0] value;
    logic [pli_pkg::IDX_W-1:0]  index;
    logic [pli_pkg::IDX_W-1:0]  count;
    logic                       last;
  } list_word_t;

  list_word_t                 due_words[$];
  logic [pli_pkg::DATA_W-1:0] shadow_vals[DEPTH];
  int                         shadow_len = 0;
  int                         n_fail = 0;
  int                         n_due = 0;

  assign fail_count = n_fail;
  assign due_count  = n_due;

  function automatic list_word_t make_word(logic [1:0] st, logic [pli_pkg::DATA_W-1:0] v,
                                           int idx, int cnt, logic lst);
    list_word_t w;
    w.status = st;
    w.value  = v;
    w.index  = pli_pkg::IDX_W'(idx);
    w.count  = pli_pkg::IDX_W'(cnt);
    w.last   = lst;
    return w;
  endfunction

  // Applies one accepted word to the shadow list and queues the words it must cause.
  function automatic void predict_list_op(logic [1:0] fn, logic [pli_pkg::POS_W-1:0] pos_in,
                                          logic [pli_pkg::DATA_W-1:0] val);
    int p;
    p = int'(pos_in);
    case (fn)
      pli_pkg::FUNC_INSERT: begin
        if (shadow_len >= DEPTH) begin
          due_words.push_back(make_word(pli_pkg::STAT_FULL, '0, 0, shadow_len, 1'b1));
        end else if (p < 1 || p > shadow_len + 1) begin
          due_words.push_back(make_word(pli_pkg::STAT_WRONG_POS, '0, 0, shadow_len, 1'b1));
        end else begin
          for (int k = shadow_len; k > p - 1; k--) shadow_vals[k] = shadow_vals[k-1];
          shadow_vals[p-1] = val;
          shadow_len++;
          due_words.push_back(make_word(pli_pkg::STAT_OK, '0, 0, shadow_len, 1'b1));
        end
      end
      pli_pkg::FUNC_DELETE: begin
        if (shadow_len == 0) begin
          due_words.push_back(make_word(pli_pkg::STAT_EMPTY, '0, 0, 0, 1'b1));
        end else if (p < 1 || p > shadow_len) begin
          due_words.push_back(make_word(pli_pkg::STAT_WRONG_POS, '0, 0, shadow_len, 1'b1));
        end else begin
          for (int k = p - 1; k + 1 < shadow_len; k++) shadow_vals[k] = shadow_vals[k+1];
          shadow_len--;
          due_words.push_back(make_word(pli_pkg::STAT_OK, '0, 0, shadow_len, 1'b1));
        end
      end
      pli_pkg::FUNC_LIST: begin
        if (shadow_len == 0) begin
          due_words.push_back(make_word(pli_pkg::STAT_EMPTY, '0, 0, 0, 1'b1));
        end else begin
          for (int k = 0; k < shadow_len; k++) begin
            due_words.push_back(make_word(pli_pkg::STAT_OK, shadow_vals[k], k + 1,
                                          shadow_len, k + 1 == shadow_len));
          end
        end
      end
      default: begin
        due_words.push_back(make_word(pli_pkg::STAT_OK, '0, 0, shadow_len, 1'b1));
      end
    endcase
  endfunction

  function automatic void check_word(list_word_t got);
    list_word_t want;
    if (due_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %h", $time, got);
      n_fail++;
      return;
    end
    want = due_words.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      n_fail++;
    end
    if (got.value !== want.value) begin
      $display("%0t: entry_value expected %h actual %h", $time, want.value, got.value);
      n_fail++;
    end
    if (got.index !== want.index) begin
      $display("%0t: entry_index expected %0d actual %0d", $time, want.index, got.index);
      n_fail++;
    end
    if (got.count !== want.count) begin
      $display("%0t: entry_count expected %0d actual %0d", $time, want.count, got.count);
      n_fail++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_len = 0;
      due_words.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        predict_list_op(in_tuser, in_tdata[pli_pkg::POS_W-1:0],
                        in_tdata[pli_pkg::POS_W+pli_pkg::DATA_W-1:pli_pkg::POS_W]);
      end
      if (out_tvalid && out_tready) begin
        check_word({out_tuser, out_tdata[31:0], out_tdata[37:32], out_tdata[43:38],
                    out_tlast});
      end
    end
    n_due = due_words.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the positional list: stimulus, output stalls and the verdict.
module tb;

  localparam int         DEPTH      = 32;
  localparam logic [1:0] FUNC_UNDEF = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          due_count;

  bit          quiet = 1'b0;
  bit          hold_rx = 1'b0;
  int          level = 0;

  always #6 clk = ~clk;

  positional_list_insert_delete #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  list_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  // The level only steers positions toward valid ones; the checker does the predicting.
  task automatic send_word(input logic [1:0] fn, input logic [pli_pkg::POS_W-1:0] pos,
                           input logic [pli_pkg::DATA_W-1:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {2'b00, val, pos};
    do @(posedge clk); while (!in_tready);
    case (fn)
      pli_pkg::FUNC_INSERT: if (level < DEPTH && pos >= 1 && pos <= level + 1) level++;
      pli_pkg::FUNC_DELETE: if (level > 0 && pos >= 1 && pos <= level) level--;
      default: ;
    endcase
  endtask

  task automatic send_random_word(input int ins_pct);
    int                         r;
    logic [1:0]                 fn;
    logic [pli_pkg::POS_W-1:0]  pos;
    logic [pli_pkg::DATA_W-1:0] val;
    r = $urandom_range(0, 99);
    if (r < 3) fn = FUNC_UNDEF;
    else if (r < 12) fn = pli_pkg::FUNC_LIST;
    else if ($urandom_range(0, 99) < ins_pct) fn = pli_pkg::FUNC_INSERT;
    else fn = pli_pkg::FUNC_DELETE;
    if ($urandom_range(0, 9) < 8) begin
      if (fn == pli_pkg::FUNC_DELETE && level > 0) begin
        pos = pli_pkg::POS_W'($urandom_range(1, level));
      end else begin
        pos = pli_pkg::POS_W'($urandom_range(1, level + 1));
      end
    end else begin
      pos = pli_pkg::POS_W'($urandom_range(0, 63));
    end
    case ($urandom_range(0, 7))
      0: val = 32'h8000_0000;
      1: val = 32'h7FFF_FFFF;
      default: val = $urandom;
    endcase
    send_word(fn, pos, val);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (due_count == 0);
    @(posedge clk);
  endtask

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_rx = 1'b0;
      end
      n = quiet ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid && !hold_rx);
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(pli_pkg::FUNC_LIST,   0,  32'hFFFF_FFFF);
    send_word(pli_pkg::FUNC_DELETE, 1,  32'h0);
    send_word(pli_pkg::FUNC_DELETE, 63, 32'h0);
    send_word(pli_pkg::FUNC_INSERT, 0,  32'h1234_5678);
    send_word(pli_pkg::FUNC_INSERT, 2,  32'h1234_5678);
    send_word(pli_pkg::FUNC_INSERT, 63, 32'h1234_5678);
    send_word(pli_pkg::FUNC_INSERT, 1,  32'h8000_0000);
    send_word(pli_pkg::FUNC_INSERT, 2,  32'h7FFF_FFFF);
    send_word(pli_pkg::FUNC_INSERT, 1,  32'hFFFF_FFFF);
    send_word(pli_pkg::FUNC_INSERT, 2,  32'h0);
    send_word(pli_pkg::FUNC_LIST,   63, 32'h0);
    send_word(pli_pkg::FUNC_DELETE, 0,  32'h0);
    send_word(pli_pkg::FUNC_DELETE, 5,  32'h0);
    send_word(pli_pkg::FUNC_DELETE, 63, 32'h0);
    send_word(pli_pkg::FUNC_DELETE, 2,  32'h0);
    send_word(pli_pkg::FUNC_DELETE, 3,  32'h0);
    send_word(FUNC_UNDEF,           63, 32'hFFFF_FFFF);
    send_word(pli_pkg::FUNC_LIST,   0,  32'h0);
    send_word(pli_pkg::FUNC_DELETE, 1,  32'h0);
    send_word(pli_pkg::FUNC_DELETE, 1,  32'h0);
    send_word(pli_pkg::FUNC_LIST,   0,  32'h0);
    send_word(FUNC_UNDEF,           0,  32'h0);

    repeat (DEPTH) begin
      send_word(pli_pkg::FUNC_INSERT, pli_pkg::POS_W'($urandom_range(1, level + 1)), $urandom);
    end
    send_word(pli_pkg::FUNC_INSERT, 0,  $urandom);
    send_word(pli_pkg::FUNC_INSERT, 63, $urandom);
    send_word(pli_pkg::FUNC_INSERT, pli_pkg::POS_W'(DEPTH + 1), $urandom);
    hold_rx = 1'b1;
    send_word(pli_pkg::FUNC_LIST, 0, $urandom);
    send_word(pli_pkg::FUNC_DELETE, pli_pkg::POS_W'(DEPTH), $urandom);
    send_word(pli_pkg::FUNC_INSERT, 1, $urandom);
    send_word(pli_pkg::FUNC_LIST, 0, $urandom);
    while (level > 0) begin
      send_word(pli_pkg::FUNC_DELETE, pli_pkg::POS_W'($urandom_range(1, level)), $urandom);
    end
    send_word(pli_pkg::FUNC_DELETE, 1, $urandom);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      quiet = (phase == 3 || phase == 6);
      if (phase == 5) drain();
      repeat (38) send_random_word((phase % 2 == 0) ? 80 : 35);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
